// ===== rtl/plba_pkg.sv =====
// ----------------------------------------------------------------------------
// plba_pkg
// Shared constants, types and the arctangent table for the polyline length
// and bend angle engine.
// ----------------------------------------------------------------------------
package plba_pkg;

    // Result field widths
    localparam int LEN_W = 25;
    localparam int ANG_W = 16;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Angle units: pi = 32768
    localparam int ANGLE_PI   = 32768;
    localparam int ANGLE_HALF = 16384;

    // Component bound of the first scaling step (2^24)
    localparam logic [63:0] SCALE_LIM = 64'd16777216;

    // Cross/dot magnitudes are brought below 2^30 before the angle step
    localparam int J_SHIFT = 30;

    // CORDIC sizing
    localparam int CORDIC_STEPS = 15;
    localparam int STEP_W       = 4;
    localparam int ATAN_W       = 14;
    localparam int CIN_X_W      = 30;
    localparam int CIN_Y_W      = 32;
    localparam int CORDIC_W     = 34;
    localparam int ZW           = 16;
    localparam int ZOUT_W       = 15;

    // Multiply-accumulate control
    typedef struct packed {
        logic start;
        logic clr;
        logic sub;
    } t_mac_ctl;

    // atan(2^-i) in angle units
    function automatic logic [ATAN_W-1:0] atan_val(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] v;
        unique case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/plba_if.sv =====
// ----------------------------------------------------------------------------
// plba_if
// Valid/ready channels: path point input and segment result output.
// ----------------------------------------------------------------------------

// Point channel
interface plba_in_if #(
    parameter int COORD_WIDTH = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic                          start_req;

    modport source (output valid, x, y, z, start_req, input ready);
    modport sink   (input valid, x, y, z, start_req, output ready);
endinterface

// Result channel
interface plba_out_if import plba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] seg_length;
    logic [ANG_W-1:0] bend_angle;
    logic             angle_valid;
    logic             degenerate;

    modport source (output valid, seg_length, bend_angle, angle_valid, degenerate,
                    input ready);
    modport sink   (input valid, seg_length, bend_angle, angle_valid, degenerate,
                    output ready);
endinterface

// ===== rtl/plba_mac.sv =====
// ----------------------------------------------------------------------------
// plba_mac
// Bit-serial shift-add multiply-accumulate: one multiplier bit per cycle,
// finishes as soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module plba_mac import plba_pkg::*; #(
    parameter int MW = 30,
    parameter int AW = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mac_ctl             i_ctl,
    input  logic [MW-1:0]        i_a,
    input  logic [MW-1:0]        i_b,
    output logic                 o_busy,
    output logic signed [AW-1:0] o_acc
);

    logic [AW-1:0] r_a, n_a;
    logic [MW-1:0] r_b, n_b;
    logic          r_sub, n_sub;
    logic [AW-1:0] r_acc, n_acc;

    // Load on start, then add/subtract the shifted multiplicand per set bit
    always_comb begin
        n_a   = r_a;
        n_b   = r_b;
        n_sub = r_sub;
        n_acc = r_acc;
        if (i_ctl.start) begin
            n_a   = AW'(i_a);
            n_b   = i_b;
            n_sub = i_ctl.sub;
            if (i_ctl.clr) begin
                n_acc = '0;
            end
        end else if (r_b != '0) begin
            if (r_b[0]) begin
                n_acc = r_sub ? (r_acc - r_a) : (r_acc + r_a);
            end
            n_a = r_a << 1;
            n_b = r_b >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= '0;
        end else begin
            r_b <= n_b;
        end
        r_a   <= n_a;
        r_sub <= n_sub;
        r_acc <= n_acc;
    end

    assign o_busy = (r_b != '0);
    assign o_acc  = $signed(r_acc);

endmodule

// ===== rtl/plba_sqrt.sv =====
// ----------------------------------------------------------------------------
// plba_sqrt
// Restoring integer square root, two radicand bits per cycle. Gives the
// floor root and the remainder (radicand minus root squared).
// ----------------------------------------------------------------------------
module plba_sqrt import plba_pkg::*; #(
    parameter int AW = 63
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [AW-1:0]               i_rad,
    output logic                        o_busy,
    output logic [(AW+1)/2-1:0]         o_root,
    output logic [(AW+1)/2+1:0]         o_rem
);

    localparam int RTW   = (AW + 1) / 2;
    localparam int SQW   = 2 * RTW;
    localparam int REMW  = RTW + 2;
    localparam int CNT_W = $clog2(RTW + 1);

    logic [SQW-1:0]   r_rad, n_rad;
    logic [REMW-1:0]  r_rem, n_rem;
    logic [RTW-1:0]   r_root, n_root;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [REMW+1:0]  w_cur;
    logic [REMW+1:0]  w_trial;

    // One root digit per cycle
    always_comb begin
        n_rad   = r_rad;
        n_rem   = r_rem;
        n_root  = r_root;
        n_cnt   = r_cnt;
        w_cur   = {r_rem, r_rad[SQW-1 -: 2]};
        w_trial = (REMW+2)'({r_root, 2'b01});
        if (i_start) begin
            n_rad  = SQW'(i_rad);
            n_rem  = '0;
            n_root = '0;
            n_cnt  = CNT_W'(RTW);
        end else if (r_cnt != '0) begin
            if (w_cur >= w_trial) begin
                n_rem  = REMW'(w_cur - w_trial);
                n_root = {r_root[RTW-2:0], 1'b1};
            end else begin
                n_rem  = REMW'(w_cur);
                n_root = {r_root[RTW-2:0], 1'b0};
            end
            n_rad = r_rad << 2;
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_busy = (r_cnt != '0);
    assign o_root = r_root;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/plba_cordic.sv =====
// ----------------------------------------------------------------------------
// plba_cordic
// Vectoring CORDIC, one rotation per cycle, stops early when Y reaches zero.
// Result is the accumulated angle clamped to 0..pi/2.
// ----------------------------------------------------------------------------
module plba_cordic import plba_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [CIN_X_W-1:0] i_x,
    input  logic [CIN_Y_W-1:0] i_y,
    output logic               o_busy,
    output logic [ZOUT_W-1:0]  o_z
);

    logic [CORDIC_W-1:0] r_x, n_x;
    logic [CORDIC_W-1:0] r_y, n_y;
    logic [ZW-1:0]       r_z, n_z;
    logic [STEP_W-1:0]   r_i, n_i;
    logic                r_run, n_run;
    logic [CORDIC_W-1:0] w_ym;
    logic [CORDIC_W-1:0] w_ysh;
    logic [CORDIC_W-1:0] w_xsh;
    logic [ZW-1:0]       w_t;

    // Shifts act on magnitudes so negative values truncate toward zero
    always_comb begin
        w_ym  = r_y[CORDIC_W-1] ? (~r_y + 1'b1) : r_y;
        w_ysh = w_ym >> r_i;
        w_xsh = r_x >> r_i;
        w_t   = ZW'(atan_val(r_i));
        n_x   = r_x;
        n_y   = r_y;
        n_z   = r_z;
        n_i   = r_i;
        n_run = r_run;
        if (i_start) begin
            n_x   = CORDIC_W'(i_x);
            n_y   = CORDIC_W'(i_y);
            n_z   = '0;
            n_i   = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            if (r_y == '0 || r_i == STEP_W'(CORDIC_STEPS)) begin
                n_run = 1'b0;
            end else begin
                n_x = r_x + w_ysh;
                n_y = r_y[CORDIC_W-1] ? (r_y + w_xsh) : (r_y - w_xsh);
                n_z = r_y[CORDIC_W-1] ? (r_z - w_t) : (r_z + w_t);
                n_i = r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= n_run;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_i <= n_i;
    end

    // Clamp to 0..pi/2
    always_comb begin
        if (r_z[ZW-1]) begin
            o_z = '0;
        end else if (r_z > ZW'(ANGLE_HALF)) begin
            o_z = ZOUT_W'(ANGLE_HALF);
        end else begin
            o_z = ZOUT_W'(r_z);
        end
    end

    assign o_busy = r_run;

endmodule

// ===== rtl/polyline_length_and_bend_angle_top.sv =====
// ----------------------------------------------------------------------------
// polyline_length_and_bend_angle_top
// Takes 3D path points one transaction at a time and returns, for every point
// after the first of a path, the rounded segment length and the bend angle at
// the previous vertex (pi = 32768). A point is taken only while the engine is
// idle; a finished result sits in the output register while the next point is
// already being worked on. The first point of a path is only stored. Other
// points are worked on by one bit-serial shift-add multiplier (one multiplier
// bit per cycle), one two-bits-per-cycle square root and a 15-step CORDIC;
// for a bent point the work is set mostly by the fifteen serial products.
// ----------------------------------------------------------------------------
module polyline_length_and_bend_angle_top import plba_pkg::*; #(
    parameter int COORD_WIDTH = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plba_in_if.sink   i_pt,
    plba_out_if.source o_res
);

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int MW   = (DW > 30) ? DW : 30;
    localparam int AW   = 2 * MW + 3;
    localparam int RTW  = (AW + 1) / 2;
    localparam int REMW = RTW + 2;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_MWAIT = 4'd2;
    localparam logic [3:0] S_LSQ   = 4'd3;
    localparam logic [3:0] S_LWAIT = 4'd4;
    localparam logic [3:0] S_SCLK  = 4'd5;
    localparam logic [3:0] S_SCLJ  = 4'd6;
    localparam logic [3:0] S_YSQ   = 4'd7;
    localparam logic [3:0] S_YWAIT = 4'd8;
    localparam logic [3:0] S_COR   = 4'd9;
    localparam logic [3:0] S_CWAIT = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    // Product schedule
    localparam logic [3:0] OP_LEN_FIRST = 4'd0;
    localparam logic [3:0] OP_LEN_MID   = 4'd1;
    localparam logic [3:0] OP_LEN_LAST  = 4'd2;
    localparam logic [3:0] OP_DOT_FIRST = 4'd3;
    localparam logic [3:0] OP_DOT_MID   = 4'd4;
    localparam logic [3:0] OP_DOT_LAST  = 4'd5;
    localparam logic [3:0] OP_C0_FIRST  = 4'd6;
    localparam logic [3:0] OP_C0_LAST   = 4'd7;
    localparam logic [3:0] OP_C1_FIRST  = 4'd8;
    localparam logic [3:0] OP_C1_LAST   = 4'd9;
    localparam logic [3:0] OP_C2_FIRST  = 4'd10;
    localparam logic [3:0] OP_C2_LAST   = 4'd11;
    localparam logic [3:0] OP_SQ_FIRST  = 4'd12;
    localparam logic [3:0] OP_SQ_MID    = 4'd13;
    localparam logic [3:0] OP_SQ_LAST   = 4'd14;

    function automatic logic [DW-1:0] mag_d(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [AW-1:0] mag_a(input logic [AW-1:0] v);
        return v[AW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic over_lim(input logic [DW-1:0] m);
        return ({{(64-DW){1'b0}}, m} > SCALE_LIM);
    endfunction

    logic [3:0]       r_state, n_state;
    logic [1:0]       r_seen, n_seen;
    logic [CW-1:0]    r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic [DW-1:0]    r_pd [3];
    logic [DW-1:0]    n_pd [3];
    logic [DW-1:0]    r_um [3];
    logic [DW-1:0]    n_um [3];
    logic [DW-1:0]    r_dm [3];
    logic [DW-1:0]    n_dm [3];
    logic [2:0]       r_us, n_us, r_ds, n_ds;
    logic             r_valid, n_valid;
    logic             r_degen, n_degen;
    logic [3:0]       r_op, n_op;
    logic             r_dot_neg, n_dot_neg;
    logic [AW-1:0]    r_dotm, n_dotm;
    logic [AW-1:0]    r_cm [3];
    logic [AW-1:0]    n_cm [3];
    logic [LEN_W-1:0] r_len, n_len;
    logic [ANG_W-1:0] r_ang, n_ang;
    logic             r_ov, n_ov;
    logic [LEN_W-1:0] r_o_len, n_o_len;
    logic [ANG_W-1:0] r_o_ang, n_o_ang;
    logic             r_o_av, n_o_av;
    logic             r_o_dg, n_o_dg;

    logic [DW-1:0]        w_d [3];
    logic                 w_accept;
    t_mac_ctl             w_mac_ctl;
    logic [MW-1:0]        w_mac_a;
    logic [MW-1:0]        w_mac_b;
    logic                 w_mac_busy;
    logic signed [AW-1:0] w_acc;
    logic                 w_sq_start;
    logic                 w_sq_busy;
    logic [RTW-1:0]       w_root;
    logic [REMW-1:0]      w_rem;
    logic [RTW:0]         w_len_full;
    logic                 w_cor_start;
    logic                 w_cor_busy;
    logic [ZOUT_W-1:0]    w_z;
    logic                 w_kbig;
    logic                 w_jbig;

    // New segment vector
    assign w_d[0] = {i_pt.x[CW-1], i_pt.x} - {r_px[CW-1], r_px};
    assign w_d[1] = {i_pt.y[CW-1], i_pt.y} - {r_py[CW-1], r_py};
    assign w_d[2] = {i_pt.z[CW-1], i_pt.z} - {r_pz[CW-1], r_pz};

    assign i_pt.ready = (r_state == S_IDLE);
    assign w_accept   = i_pt.valid && (r_state == S_IDLE);

    // Operand selection for the serial multiplier
    always_comb begin
        w_mac_ctl.start = (r_state == S_MUL);
        w_mac_ctl.clr   = 1'b0;
        w_mac_ctl.sub   = 1'b0;
        w_mac_a         = '0;
        w_mac_b         = '0;
        unique case (r_op)
            OP_LEN_FIRST, OP_LEN_MID, OP_LEN_LAST: begin
                w_mac_a       = MW'(r_dm[r_op[1:0]]);
                w_mac_b       = MW'(r_dm[r_op[1:0]]);
                w_mac_ctl.clr = (r_op == OP_LEN_FIRST);
            end
            OP_DOT_FIRST: begin
                w_mac_a = MW'(r_um[0]); w_mac_b = MW'(r_dm[0]);
                w_mac_ctl.sub = r_us[0] ^ r_ds[0];
                w_mac_ctl.clr = 1'b1;
            end
            OP_DOT_MID: begin
                w_mac_a = MW'(r_um[1]); w_mac_b = MW'(r_dm[1]);
                w_mac_ctl.sub = r_us[1] ^ r_ds[1];
            end
            OP_DOT_LAST: begin
                w_mac_a = MW'(r_um[2]); w_mac_b = MW'(r_dm[2]);
                w_mac_ctl.sub = r_us[2] ^ r_ds[2];
            end
            OP_C0_FIRST: begin
                w_mac_a = MW'(r_um[1]); w_mac_b = MW'(r_dm[2]);
                w_mac_ctl.sub = r_us[1] ^ r_ds[2];
                w_mac_ctl.clr = 1'b1;
            end
            OP_C0_LAST: begin
                w_mac_a = MW'(r_um[2]); w_mac_b = MW'(r_dm[1]);
                w_mac_ctl.sub = ~(r_us[2] ^ r_ds[1]);
            end
            OP_C1_FIRST: begin
                w_mac_a = MW'(r_um[2]); w_mac_b = MW'(r_dm[0]);
                w_mac_ctl.sub = r_us[2] ^ r_ds[0];
                w_mac_ctl.clr = 1'b1;
            end
            OP_C1_LAST: begin
                w_mac_a = MW'(r_um[0]); w_mac_b = MW'(r_dm[2]);
                w_mac_ctl.sub = ~(r_us[0] ^ r_ds[2]);
            end
            OP_C2_FIRST: begin
                w_mac_a = MW'(r_um[0]); w_mac_b = MW'(r_dm[1]);
                w_mac_ctl.sub = r_us[0] ^ r_ds[1];
                w_mac_ctl.clr = 1'b1;
            end
            OP_C2_LAST: begin
                w_mac_a = MW'(r_um[1]); w_mac_b = MW'(r_dm[0]);
                w_mac_ctl.sub = ~(r_us[1] ^ r_ds[0]);
            end
            OP_SQ_FIRST, OP_SQ_MID, OP_SQ_LAST: begin
                w_mac_a       = r_cm[r_op[1:0]][MW-1:0];
                w_mac_b       = r_cm[r_op[1:0]][MW-1:0];
                w_mac_ctl.clr = (r_op == OP_SQ_FIRST);
            end
            default: begin
                w_mac_a = '0;
            end
        endcase
    end

    // Rounded, saturated length from root and remainder
    assign w_len_full = {1'b0, w_root} + (RTW+1)'(w_rem > REMW'(w_root));

    assign w_kbig = over_lim(r_um[0]) | over_lim(r_um[1]) | over_lim(r_um[2]) |
                    over_lim(r_dm[0]) | over_lim(r_dm[1]) | over_lim(r_dm[2]);
    assign w_jbig = (|r_dotm[AW-1:J_SHIFT]) | (|r_cm[0][AW-1:J_SHIFT]) |
                    (|r_cm[1][AW-1:J_SHIFT]) | (|r_cm[2][AW-1:J_SHIFT]);

    assign w_sq_start  = (r_state == S_LSQ) || (r_state == S_YSQ);
    assign w_cor_start = (r_state == S_COR);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_seen    = r_seen;
        n_px      = r_px;
        n_py      = r_py;
        n_pz      = r_pz;
        n_pd      = r_pd;
        n_um      = r_um;
        n_dm      = r_dm;
        n_us      = r_us;
        n_ds      = r_ds;
        n_valid   = r_valid;
        n_degen   = r_degen;
        n_op      = r_op;
        n_dot_neg = r_dot_neg;
        n_dotm    = r_dotm;
        n_cm      = r_cm;
        n_len     = r_len;
        n_ang     = r_ang;
        n_ov      = r_ov;
        n_o_len   = r_o_len;
        n_o_ang   = r_o_ang;
        n_o_av    = r_o_av;
        n_o_dg    = r_o_dg;

        // Output register drains independently
        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_px = i_pt.x;
                    n_py = i_pt.y;
                    n_pz = i_pt.z;
                    if (i_pt.start_req || r_seen == 2'd0) begin
                        n_seen = 2'd1;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            n_dm[i] = mag_d(w_d[i]);
                            n_ds[i] = w_d[i][DW-1];
                            n_um[i] = mag_d(r_pd[i]);
                            n_us[i] = r_pd[i][DW-1];
                            n_pd[i] = w_d[i];
                        end
                        n_valid = (r_seen == 2'd2);
                        n_degen = ((w_d[0] == '0) && (w_d[1] == '0) && (w_d[2] == '0)) ||
                                  ((r_seen == 2'd2) && (r_pd[0] == '0) &&
                                   (r_pd[1] == '0) && (r_pd[2] == '0));
                        n_seen  = 2'd2;
                        n_op    = OP_LEN_FIRST;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                if (!w_mac_busy) begin
                    n_op    = r_op + 1'b1;
                    n_state = S_MUL;
                    case (r_op)
                        OP_LEN_LAST: n_state = S_LSQ;
                        OP_DOT_LAST: begin
                            n_dot_neg = w_acc[AW-1];
                            n_dotm    = mag_a(w_acc);
                        end
                        OP_C0_LAST: n_cm[0] = mag_a(w_acc);
                        OP_C1_LAST: n_cm[1] = mag_a(w_acc);
                        OP_C2_LAST: begin
                            n_cm[2] = mag_a(w_acc);
                            n_state = S_SCLJ;
                        end
                        OP_SQ_LAST: n_state = S_YSQ;
                        default: n_state = S_MUL;
                    endcase
                end
            end
            S_LSQ: begin
                n_state = S_LWAIT;
            end
            S_LWAIT: begin
                if (!w_sq_busy) begin
                    n_len = (w_len_full > (RTW+1)'(LEN_MAX)) ? LEN_MAX
                                                             : LEN_W'(w_len_full);
                    if (r_valid && !r_degen) begin
                        n_op    = OP_DOT_FIRST;
                        n_state = S_SCLK;
                    end else begin
                        n_ang   = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_SCLK: begin
                // Shift all six components until each is at most 2^24
                if (w_kbig) begin
                    for (int i = 0; i < 3; i++) begin
                        n_um[i] = r_um[i] >> 1;
                        n_dm[i] = r_dm[i] >> 1;
                    end
                end else begin
                    n_state = S_MUL;
                end
            end
            S_SCLJ: begin
                // Shift dot and cross magnitudes until all are below 2^30
                if (w_jbig) begin
                    n_dotm = r_dotm >> 1;
                    for (int i = 0; i < 3; i++) begin
                        n_cm[i] = r_cm[i] >> 1;
                    end
                end else begin
                    n_op    = OP_SQ_FIRST;
                    n_state = S_MUL;
                end
            end
            S_YSQ: begin
                n_state = S_YWAIT;
            end
            S_YWAIT: begin
                if (!w_sq_busy) begin
                    n_state = S_COR;
                end
            end
            S_COR: begin
                n_state = S_CWAIT;
            end
            S_CWAIT: begin
                if (!w_cor_busy) begin
                    n_ang   = r_dot_neg ? (ANG_W'(ANGLE_PI) - ANG_W'(w_z)) : ANG_W'(w_z);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || o_res.ready) begin
                    n_ov    = 1'b1;
                    n_o_len = r_len;
                    n_o_ang = r_ang;
                    n_o_av  = r_valid;
                    n_o_dg  = r_degen;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen  <= 2'd0;
            r_ov    <= 1'b0;
            r_px    <= '0;
            r_py    <= '0;
            r_pz    <= '0;
            r_pd    <= '{default: '0};
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            r_ov    <= n_ov;
            r_px    <= n_px;
            r_py    <= n_py;
            r_pz    <= n_pz;
            r_pd    <= n_pd;
        end
        r_um      <= n_um;
        r_dm      <= n_dm;
        r_us      <= n_us;
        r_ds      <= n_ds;
        r_valid   <= n_valid;
        r_degen   <= n_degen;
        r_op      <= n_op;
        r_dot_neg <= n_dot_neg;
        r_dotm    <= n_dotm;
        r_cm      <= n_cm;
        r_len     <= n_len;
        r_ang     <= n_ang;
        r_o_len   <= n_o_len;
        r_o_ang   <= n_o_ang;
        r_o_av    <= n_o_av;
        r_o_dg    <= n_o_dg;
    end

    // Result channel
    assign o_res.valid       = r_ov;
    assign o_res.seg_length  = r_o_len;
    assign o_res.bend_angle  = r_o_ang;
    assign o_res.angle_valid = r_o_av;
    assign o_res.degenerate  = r_o_dg;

    plba_mac #(
        .MW (MW),
        .AW (AW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_busy  (w_mac_busy),
        .o_acc   (w_acc)
    );

    plba_sqrt #(
        .AW (AW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   ($unsigned(w_acc)),
        .o_busy  (w_sq_busy),
        .o_root  (w_root),
        .o_rem   (w_rem)
    );

    plba_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_x     (r_dotm[CIN_X_W-1:0]),
        .i_y     (w_root[CIN_Y_W-1:0]),
        .o_busy  (w_cor_busy),
        .o_z     (w_z)
    );

endmodule
